[src/pngunf_pkg.sv]
// shared constants, codes and types of the png scanline unfilter
package pngunf_pkg;

  // default sizing
  localparam int unsigned MaxRowBytesDef   = 8192;
  localparam int unsigned MaxPixelBytesDef = 8;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned BppW  = 4;

  // bytes per pixel after reset
  localparam logic [BppW-1:0] BppReset = 4'd3;

  // filter type codes of a row header
  localparam logic [ByteW-1:0] FilterNone    = 8'd0;
  localparam logic [ByteW-1:0] FilterSub     = 8'd1;
  localparam logic [ByteW-1:0] FilterUp      = 8'd2;
  localparam logic [ByteW-1:0] FilterAverage = 8'd3;
  localparam logic [ByteW-1:0] FilterPaeth   = 8'd4;
  localparam logic [ByteW-1:0] BadFilterMin  = 8'd5;

  // item kind codes
  localparam logic KindHeader = 1'b0;
  localparam logic KindData   = 1'b1;

  // neighbour bytes of the byte being reconstructed
  typedef struct packed {
    logic [ByteW-1:0] a;  // left
    logic [ByteW-1:0] b;  // above
    logic [ByteW-1:0] c;  // above-left
  } pngunf_nbr_t;

endpackage

[src/pngunf_if.sv]
// valid/ready channel interfaces of the png scanline unfilter
interface pngunf_in_if
  import pngunf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ByteW-1:0] value;
  logic             new_pass;

  modport source (output valid, kind, value, new_pass, input ready);
  modport sink   (input valid, kind, value, new_pass, output ready);
endinterface

interface pngunf_out_if
  import pngunf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] pixel_byte;
  logic             bad_filter;

  modport source (output valid, pixel_byte, bad_filter, input ready);
  modport sink   (input valid, pixel_byte, bad_filter, output ready);
endinterface

interface pngunf_cfg_if
  import pngunf_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [BppW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[src/pngunf_line_ram.sv]
// line store of the previous row: one write port, one registered read port
module pngunf_line_ram
  import pngunf_pkg::*;
#(
  parameter int unsigned Depth = MaxRowBytesDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [ByteW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem_q [Depth];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/pngunf_predict.sv]
// filter predictor: none, sub, up, average and paeth
module pngunf_predict
  import pngunf_pkg::*;
(
  input  logic [ByteW-1:0] filter_i,
  input  pngunf_nbr_t      nbr_i,
  output logic [ByteW-1:0] pred_o
);

  logic [ByteW:0]   sum_ab;
  logic [ByteW:0]   two_c;
  logic [ByteW-1:0] pa;
  logic [ByteW-1:0] pb;
  logic [ByteW:0]   pc;
  logic [ByteW-1:0] paeth;

  assign sum_ab = {1'b0, nbr_i.a} + {1'b0, nbr_i.b};
  assign two_c  = {nbr_i.c, 1'b0};

  // distances of a + b - c to a, b and c
  assign pa = (nbr_i.b >= nbr_i.c) ? nbr_i.b - nbr_i.c : nbr_i.c - nbr_i.b;
  assign pb = (nbr_i.a >= nbr_i.c) ? nbr_i.a - nbr_i.c : nbr_i.c - nbr_i.a;
  assign pc = (sum_ab >= two_c) ? sum_ab - two_c : two_c - sum_ab;

  always_comb begin
    if ((pa <= pb) && ({1'b0, pa} <= pc)) begin
      paeth = nbr_i.a;
    end else if ({1'b0, pb} <= pc) begin
      paeth = nbr_i.b;
    end else begin
      paeth = nbr_i.c;
    end
  end

  always_comb begin
    case (filter_i)
      FilterSub:     pred_o = nbr_i.a;
      FilterUp:      pred_o = nbr_i.b;
      FilterAverage: pred_o = sum_ab[ByteW:1];
      FilterPaeth:   pred_o = paeth;
      default:       pred_o = '0;  // none and bad filter types
    endcase
  end

endmodule

[src/png_scanline_unfilter_top.sv]
// png scanline unfilter: top level with input stage, row state and output register
//
// Reconstructs filtered png scanline bytes at one byte per clock unless the output
// stalls. A header beat (kind 0) sets the row's filter type and, with new_pass,
// marks a row with no row above; each data beat (kind 1) yields one reconstructed
// byte, a header yields nothing. Throughput is one beat per cycle in steady state
// when the output is not stalled; an accepted data byte is rebuilt in the work
// stage and moves into the output register once that is free. The limit is the
// previous-row line store: one write and one registered read a cycle, the read
// issued as the beat is accepted and the write done when the byte is rebuilt.
// There is one internal stage plus the output register, so one more beat can be
// taken while a finished byte waits. The line store has no clearing pass and needs
// none; bytes of a row longer than the row above read stale store contents. Filter
// types of five and up pass bytes through unchanged with bad_filter set. The user
// writes bytes_per_pixel through the config channel only while the block is idle;
// the block does not check it. 0 acts as 1, above MAX_PIXEL_BYTES as the maximum.
module png_scanline_unfilter_top
  import pngunf_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES   = MaxRowBytesDef,
  parameter int unsigned MAX_PIXEL_BYTES = MaxPixelBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pngunf_in_if.sink   in_i,
  pngunf_out_if.source out_o,
  pngunf_cfg_if.sink  cfg_i
);

  localparam int unsigned AddrW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned ColW  = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned PixW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // config register
  logic [BppW-1:0] bpp_q;

  // column counter on the accept side, drives the line store read
  logic [ColW-1:0] col_q, col_d;
  logic            col_in_range;

  // work stage
  logic             s1_vld_q, s1_vld_d;
  logic             s1_kind_q;
  logic [ByteW-1:0] s1_val_q;
  logic             s1_np_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_inr_q;

  // row state
  logic [ByteW-1:0] left_q  [MAX_PIXEL_BYTES];
  logic [ByteW-1:0] abl_q   [MAX_PIXEL_BYTES];
  logic [ByteW-1:0] filter_q;
  logic             prior_vld_q;
  logic             row_seen_q;

  // output register
  logic             out_vld_q;
  logic [ByteW-1:0] pix_q;
  logic             bad_q;

  logic             in_fire;
  logic             out_free;
  logic             s1_fire;
  logic             s1_data_fire;
  logic [BppW-1:0]  pix_dist;
  logic [PixW-1:0]  nbr_idx;
  logic [ByteW-1:0] above_raw;
  pngunf_nbr_t      nbr;
  logic [ByteW-1:0] pred;
  logic [ByteW-1:0] res;
  logic             bad;

  // config channel is always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= BppReset;
    end else if (cfg_i.valid) begin
      bpp_q <= cfg_i.data;
    end
  end

  // handshake: the stage frees up when its beat moves on
  assign out_free     = !out_vld_q || out_o.ready;
  assign s1_fire      = s1_vld_q && ((s1_kind_q == KindHeader) || out_free);
  assign s1_data_fire = s1_fire && (s1_kind_q == KindData);
  assign in_i.ready   = !s1_vld_q || s1_fire;
  assign in_fire      = in_i.valid && in_i.ready;

  // column tracking, saturates at the row limit
  assign col_in_range = (col_q < ColW'(MAX_ROW_BYTES));

  always_comb begin
    col_d = col_q;
    if (in_fire) begin
      if (in_i.kind == KindHeader) begin
        col_d = '0;
      end else if (col_in_range) begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  // line store: read at accept, write when the byte is rebuilt; within one row
  // the write address always trails the read address, across a header the write
  // lands before the next row's read
  pngunf_line_ram #(
    .Depth (MAX_ROW_BYTES),
    .AddrW (AddrW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_data_fire && s1_inr_q),
    .waddr_i (s1_addr_q),
    .wdata_i (res),
    .re_i    (in_fire && (in_i.kind == KindData) && col_in_range),
    .raddr_i (col_q[AddrW-1:0]),
    .rdata_o (above_raw)
  );

  // work stage registers
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = 1'b1;
    end else if (s1_fire) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= in_i.kind;
      s1_val_q  <= in_i.value;
      s1_np_q   <= in_i.new_pass;
      s1_addr_q <= col_q[AddrW-1:0];
      s1_inr_q  <= col_in_range;
    end
  end

  // neighbour selection, distance clamped to 1..MAX_PIXEL_BYTES
  always_comb begin
    if (bpp_q == '0) begin
      pix_dist = BppW'(1);
    end else if (bpp_q > BppW'(MAX_PIXEL_BYTES)) begin
      pix_dist = BppW'(MAX_PIXEL_BYTES);
    end else begin
      pix_dist = bpp_q;
    end
  end

  assign nbr_idx = PixW'(pix_dist - 1'b1);
  assign nbr.a   = left_q[nbr_idx];
  assign nbr.c   = abl_q[nbr_idx];
  assign nbr.b   = (prior_vld_q && s1_inr_q) ? above_raw : '0;

  pngunf_predict u_predict (
    .filter_i (filter_q),
    .nbr_i    (nbr),
    .pred_o   (pred)
  );

  assign res = s1_val_q + pred;
  assign bad = (filter_q >= BadFilterMin);

  // row state: header resets the row, data shifts the pixel history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q    <= FilterNone;
      prior_vld_q <= 1'b0;
      row_seen_q  <= 1'b0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i] <= '0;
        abl_q[i]  <= '0;
      end
    end else if (s1_fire) begin
      if (s1_kind_q == KindHeader) begin
        filter_q    <= s1_val_q;
        prior_vld_q <= row_seen_q && !s1_np_q;
        row_seen_q  <= 1'b1;
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          left_q[i] <= '0;
          abl_q[i]  <= '0;
        end
      end else begin
        for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
          left_q[i] <= left_q[i-1];
          abl_q[i]  <= abl_q[i-1];
        end
        left_q[0] <= res;
        abl_q[0]  <= nbr.b;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_data_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_data_fire) begin
      pix_q <= res;
      bad_q <= bad;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.pixel_byte = pix_q;
  assign out_o.bad_filter = bad_q;

endmodule

[src/pngunf_checker.sv]
// port-level assertions of the png scanline unfilter, bound to the top level
module pngunf_checker
  import pngunf_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             in_kind_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_pixel_byte_i,
  input logic             out_bad_filter_i
);

  // a result beat stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_pixel_byte_i) && $stable(out_bad_filter_i))
    else $error("result payload changed while stalled");

  // input back-pressure only comes from a blocked output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while output free");

  // a header beat never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_kind_i == KindHeader) |-> ##2 !$rose(out_valid_i))
    else $error("result beat after a header");

endmodule

bind png_scanline_unfilter_top pngunf_checker u_pngunf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_kind_i        (in_i.kind),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_pixel_byte_i (out_o.pixel_byte),
  .out_bad_filter_i (out_o.bad_filter)
);

[tb/png_scanline_unfilter_top_tb.sv]
// self-checking testbench of the png scanline unfilter top level
module png_scanline_unfilter_top_tb;
  import pngunf_pkg::*;

  // worst case is far below this: every beat waiting out both sides' longest idle
  localparam int unsigned CycleLimit = 3000000;
  // a header makes no byte, so after the last byte the block may still be busy
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] value;
    logic             new_pass;
  } scan_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] pixel_byte;
    logic             bad_filter;
  } pixel_t;

  // how hard both sides idle during a phase
  typedef enum logic [1:0] {
    IdleNone,
    IdleLight,
    IdleHeavy
  } idle_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pngunf_in_if  in_if ();
  pngunf_out_if out_if ();
  pngunf_cfg_if cfg_if ();

  // testbench-owned drive variables, known from time zero
  logic             drv_valid = 1'b0;
  scan_beat_t       drv_beat  = '0;
  logic             res_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [BppW-1:0]  cfg_data  = '0;

  assign in_if.valid     = drv_valid;
  assign in_if.kind      = drv_beat.kind;
  assign in_if.value     = drv_beat.value;
  assign in_if.new_pass  = drv_beat.new_pass;
  assign out_if.ready    = res_ready;
  assign cfg_if.valid    = cfg_valid;
  assign cfg_if.data     = cfg_data;

  png_scanline_unfilter_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // unfilter prediction: own copy of row state, line store and bytes per pixel
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] line_store [MaxRowBytesDef];
  logic [ByteW-1:0] left_hist [MaxPixelBytesDef]       = '{default: '0};
  logic [ByteW-1:0] above_left_hist [MaxPixelBytesDef] = '{default: '0};
  int unsigned      row_col     = 0;
  logic [ByteW-1:0] row_ftype   = FilterNone;
  logic             above_ok    = 1'b0;
  logic             hdr_seen    = 1'b0;
  logic [BppW-1:0]  bpp_cfg     = BppReset;

  pixel_t           pixel_expect_q [$];
  scan_beat_t       scan_beat_q [$];
  int unsigned      fail_cnt = 0;
  idle_mode_e       idle_mode = IdleLight;

  function automatic logic [ByteW-1:0] paeth_pick(input logic [ByteW-1:0] a,
                                                  input logic [ByteW-1:0] b,
                                                  input logic [ByteW-1:0] c);
    int pa;
    int pb;
    int pc;
    pa = int'(b) - int'(c);
    pb = int'(a) - int'(c);
    pc = int'(a) + int'(b) - 2 * int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  task automatic unfilter_model(input scan_beat_t bt);
    int unsigned      pix_dist;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] pred;
    logic [ByteW:0]   sum9;
    pixel_t           px;
    if (bt.kind == KindHeader) begin
      // first header after reset never has a row above
      above_ok  = hdr_seen && !bt.new_pass;
      hdr_seen  = 1'b1;
      row_ftype = bt.value;
      row_col   = 0;
      left_hist       = '{default: '0};
      above_left_hist = '{default: '0};
    end else begin
      pix_dist = (bpp_cfg == 0) ? 1 : int'(bpp_cfg);
      if (pix_dist > MaxPixelBytesDef) pix_dist = MaxPixelBytesDef;
      a = left_hist[pix_dist-1];
      c = above_left_hist[pix_dist-1];
      b = (above_ok && row_col < MaxRowBytesDef) ? line_store[row_col] : '0;
      case (row_ftype)
        FilterSub:     pred = a;
        FilterUp:      pred = b;
        FilterAverage: begin
          sum9 = {1'b0, a} + {1'b0, b};
          pred = sum9[ByteW:1];
        end
        FilterPaeth:   pred = paeth_pick(a, b, c);
        default:       pred = '0;
      endcase
      px.pixel_byte = bt.value + pred;
      px.bad_filter = (row_ftype >= BadFilterMin);
      for (int i = MaxPixelBytesDef - 1; i > 0; i--) begin
        left_hist[i]       = left_hist[i-1];
        above_left_hist[i] = above_left_hist[i-1];
      end
      left_hist[0]       = px.pixel_byte;
      above_left_hist[0] = b;
      // bytes past the end of the store are neither stored nor counted
      if (row_col < MaxRowBytesDef) begin
        line_store[row_col] = px.pixel_byte;
        row_col++;
      end
      pixel_expect_q.push_back(px);
    end
  endtask

  function automatic int unsigned draw_wait();
    case (idle_mode)
      IdleNone:  return 0;
      IdleLight: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      default:   return $urandom_range(0, 16);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // beat driver: pops pending beats, idles a drawn number of cycles after each
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drv_blk
    scan_beat_t nxt;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      gap_left  <= 0;
    end else if (!drv_valid || in_if.ready) begin
      // the beat on the bus was taken at this edge
      if (drv_valid) unfilter_model(drv_beat);
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        drv_valid <= 1'b0;
      end else if (scan_beat_q.size() != 0) begin
        nxt = scan_beat_q.pop_front();
        drv_beat  <= nxt;
        drv_valid <= 1'b1;
        gap_left  <= draw_wait();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compares each byte with the oldest prediction, stalls at
  // random after each one
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : mon_blk
    int unsigned n;
    pixel_t      want;
    if (!rst_ni) begin
      res_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_if.valid && res_ready) begin
      if (pixel_expect_q.size() == 0) begin
        $error("unexpected result beat: pixel_byte %0h bad_filter %0b",
               out_if.pixel_byte, out_if.bad_filter);
        fail_cnt++;
      end else begin
        want = pixel_expect_q.pop_front();
        if (out_if.pixel_byte !== want.pixel_byte) begin
          $error("pixel_byte: expected %0h, got %0h", want.pixel_byte, out_if.pixel_byte);
          fail_cnt++;
        end
        if (out_if.bad_filter !== want.bad_filter) begin
          $error("bad_filter: expected %0b, got %0b", want.bad_filter, out_if.bad_filter);
          fail_cnt++;
        end
      end
      n = draw_wait();
      if (n > 0) begin
        res_ready  <= 1'b0;
        stall_left <= n - 1;
      end else begin
        res_ready <= 1'b1;
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // run guard
  int unsigned cyc = 0;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus generation
  // the generator tracks how far the line store has been written so that no
  // row with a row above ever reads a store entry that was never written
  // ---------------------------------------------------------------------------
  int unsigned gen_row_len = 0;
  int unsigned stored_len  = 0;
  logic        gen_hdr_seen = 1'b0;
  logic        gen_above    = 1'b0;

  task automatic push_header(input logic [ByteW-1:0] ftype, input logic np);
    scan_beat_t bt;
    if (gen_row_len > stored_len) stored_len = gen_row_len;
    if (stored_len > MaxRowBytesDef) stored_len = MaxRowBytesDef;
    gen_row_len  = 0;
    gen_above    = gen_hdr_seen && !np;
    gen_hdr_seen = 1'b1;
    bt.kind     = KindHeader;
    bt.value    = ftype;
    bt.new_pass = np;
    scan_beat_q.push_back(bt);
  endtask

  task automatic push_data(input logic [ByteW-1:0] val, input logic np);
    scan_beat_t bt;
    bt.kind     = KindData;
    bt.value    = val;
    bt.new_pass = np;  // ignored on data, toggled anyway
    scan_beat_q.push_back(bt);
    gen_row_len++;
  endtask

  function automatic logic [ByteW-1:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  // one row: mostly a legal filter, sometimes bad, sometimes empty
  task automatic push_rand_row(input int unsigned max_len, output int unsigned beats);
    logic [ByteW-1:0] ftype;
    logic             np;
    int unsigned      len;
    if ($urandom_range(0, 4) != 0) ftype = ByteW'($urandom_range(0, 4));
    else if ($urandom_range(0, 1) == 0) ftype = BadFilterMin;
    else ftype = ByteW'($urandom_range(5, 255));
    np = ($urandom_range(0, 3) == 0);
    push_header(ftype, np);
    len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, max_len);
    if (gen_above && stored_len < MaxRowBytesDef && len > stored_len) len = stored_len;
    repeat (len) push_data(rand_byte(), 1'($urandom_range(0, 1)));
    beats = len + 1;
  endtask

  task automatic rand_phase(input logic [BppW-1:0] bpp, input idle_mode_e mode,
                            input int unsigned n_beats, input int unsigned max_len);
    int unsigned sent;
    int unsigned k;
    drain_pipe();
    write_bpp(bpp);
    idle_mode = mode;
    @(negedge clk_i);
    sent = 0;
    while (sent < n_beats) begin
      push_rand_row(max_len, k);
      sent += k;
    end
  endtask

  // wait until every beat is taken and every byte has come back
  task automatic drain_pipe();
    while (scan_beat_q.size() != 0 || drv_valid || pixel_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_bpp(input logic [BppW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    bpp_cfg = v;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: bytes before any header, first header without new_pass (up, no row
    // above), sub, average and paeth with the row above, bad filter on a new pass
    idle_mode = IdleLight;
    push_data(8'h00, 1'b1);
    push_data(8'hFF, 1'b0);
    push_header(FilterUp, 1'b0);
    push_data(8'h10, 1'b0);
    push_data(8'hF0, 1'b1);
    push_data(8'h7F, 1'b0);
    push_data(8'h80, 1'b1);
    push_data(8'hFF, 1'b0);
    push_header(FilterSub, 1'b0);
    repeat (4) push_data(rand_byte(), 1'b0);
    push_header(FilterAverage, 1'b0);
    repeat (4) push_data(rand_byte(), 1'b1);
    push_header(FilterPaeth, 1'b0);
    repeat (4) push_data(rand_byte(), 1'b0);
    push_header(8'hFF, 1'b1);
    push_data(8'hA5, 1'b0);

    // random rows across register settings, extremes first
    rand_phase(4'd0,  IdleHeavy, 170, 24);
    rand_phase(4'd15, IdleLight, 170, 40);
    rand_phase(4'd1,  IdleNone,  170, 40);
    rand_phase(4'd8,  IdleHeavy, 170, 40);
    rand_phase(BppW'($urandom_range(1, 8)),  IdleLight, 170, 300);
    rand_phase(BppW'($urandom_range(0, 15)), IdleHeavy, 170, 16);
    rand_phase(4'd3,  IdleNone,  170, 40);
    rand_phase(BppW'($urandom_range(1, 8)),  IdleLight, 160, 40);

    drain_pipe();
    repeat (20) @(posedge clk_i);
    if (pixel_expect_q.size() != 0) begin
      $error("pixel_byte: %0d expected bytes never arrived", pixel_expect_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[png_scanline_unfilter_top.f]
src/pngunf_pkg.sv
src/pngunf_if.sv
src/pngunf_line_ram.sv
src/pngunf_predict.sv
src/png_scanline_unfilter_top.sv
src/pngunf_checker.sv
tb/png_scanline_unfilter_top_tb.sv
